// File: rtl/core/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Default number of fraction bits for saturation, value and the channels.
  localparam int unsigned FRAC_BITS_DEF = 12;

  // Fixed widths of the pixel fields.
  localparam int unsigned HUE_W    = 16;
  localparam int unsigned CH_W     = 13;
  localparam int unsigned REM_W    = 13;
  localparam int unsigned SECTOR_W = 3;

  // Hue range and sector size in hundredths of a degree.
  localparam logic [HUE_W-1:0] HUE_MAX    = 16'd35999;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 16'd6000;

  // Hue sectors, named by the colors they run between.
  typedef enum logic [SECTOR_W-1:0] {
    SECT_RY = 3'd0,
    SECT_YG = 3'd1,
    SECT_GC = 3'd2,
    SECT_CB = 3'd3,
    SECT_BM = 3'd4,
    SECT_MR = 3'd5
  } sector_e;

endpackage

// File: rtl/core/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// Each accepted item's result is presented with valid_o high.
// Throughput: one item per clock cycle; busy_o stays low because the receiver cannot stall.
// The rate is set by a five-stage pipeline: clamp and sector split, a two-stage reciprocal
// divide for the hue fraction, and two rounds of truncating multipliers.
// Reset (rst_ni low, asynchronous) clears the stage valid bits; data registers are not reset.
module hsv_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_centideg_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  sat_q12_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  val_q12_i,
  output logic                          valid_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]  red_q12_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]  green_q12_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]  blue_q12_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned SW = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * SW;
  localparam logic [SW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int unsigned STAGES = 5;

  // Valid bits of the stages; the last one drives the strobe.
  logic [STAGES-1:0] valid_d, valid_q;

  // Stage 1 registers.
  logic [HUE_W-1:0]    hue_c;
  logic [SW-1:0]       s_c, v_c;
  logic [SECTOR_W-1:0] sect_c;
  logic [REM_W-1:0]    rem_c;
  logic [SW-1:0]       s1_s_q, s1_v_q;
  logic [SECTOR_W-1:0] s1_sect_q;
  logic [REM_W-1:0]    s1_rem_q;

  // Stage 2 and 3 registers.
  logic [PW-1:0]       base_prod;
  logic [SW-1:0]       s2_s_q, s2_v_q, s2_base_q;
  logic [SECTOR_W-1:0] s2_sect_q;
  logic [SW-1:0]       s3_s_q, s3_v_q, s3_base_q;
  logic [SECTOR_W-1:0] s3_sect_q;
  logic [FRAC_BITS-1:0] frac;

  // Stage 4 registers.
  logic [SW-1:0]       one_m_frac;
  logic [PW-1:0]       sf_prod, sfc_prod;
  logic [SW-1:0]       s4_sf_q, s4_sfc_q, s4_v_q, s4_base_q;
  logic [SECTOR_W-1:0] s4_sect_q;

  // Stage 5 logic and output registers.
  logic [PW-1:0]       fade_prod, rise_prod;
  logic [SW-1:0]       fade, rise;
  logic [SW-1:0]       red_c, green_c, blue_c;
  logic [CH_W-1:0]     red_q, green_q, blue_q;

  // The pipeline never holds, so an item is taken whenever start_i is high.
  assign busy_o  = 1'b0;
  assign valid_d = {valid_q[STAGES-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Clamp the inputs and split the hue into sector and remainder.
  assign hue_c = (hue_centideg_i > HUE_MAX) ? HUE_MAX : hue_centideg_i;
  assign s_c   = (sat_q12_i > ONE) ? ONE : SW'(sat_q12_i);
  assign v_c   = (val_q12_i > ONE) ? ONE : SW'(val_q12_i);

  always_comb begin
    if (hue_c >= HUE_W'(5 * HUE_SECTOR)) begin
      sect_c = SECT_MR;
      rem_c  = REM_W'(hue_c - HUE_W'(5 * HUE_SECTOR));
    end else if (hue_c >= HUE_W'(4 * HUE_SECTOR)) begin
      sect_c = SECT_BM;
      rem_c  = REM_W'(hue_c - HUE_W'(4 * HUE_SECTOR));
    end else if (hue_c >= HUE_W'(3 * HUE_SECTOR)) begin
      sect_c = SECT_CB;
      rem_c  = REM_W'(hue_c - HUE_W'(3 * HUE_SECTOR));
    end else if (hue_c >= HUE_W'(2 * HUE_SECTOR)) begin
      sect_c = SECT_GC;
      rem_c  = REM_W'(hue_c - HUE_W'(2 * HUE_SECTOR));
    end else if (hue_c >= HUE_SECTOR) begin
      sect_c = SECT_YG;
      rem_c  = REM_W'(hue_c - HUE_SECTOR);
    end else begin
      sect_c = SECT_RY;
      rem_c  = REM_W'(hue_c);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_s_q    <= s_c;
    s1_v_q    <= v_c;
    s1_sect_q <= sect_c;
    s1_rem_q  <= rem_c;
  end

  // The hue fraction takes two stages; the base product runs beside it.
  hsv2rgb_frac_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_frac_div (
    .clk_i (clk_i),
    .rem_i (s1_rem_q),
    .frac_o(frac)
  );

  assign base_prod = {{SW{1'b0}}, s1_v_q} * {{SW{1'b0}}, ONE - s1_s_q};

  always_ff @(posedge clk_i) begin
    s2_s_q    <= s1_s_q;
    s2_v_q    <= s1_v_q;
    s2_sect_q <= s1_sect_q;
    s2_base_q <= SW'(base_prod >> FRAC_BITS);
    s3_s_q    <= s2_s_q;
    s3_v_q    <= s2_v_q;
    s3_sect_q <= s2_sect_q;
    s3_base_q <= s2_base_q;
  end

  // Saturation scaled by the fraction and by its complement.
  assign one_m_frac = ONE - {1'b0, frac};
  assign sf_prod    = {{SW{1'b0}}, s3_s_q} * {{(SW+1){1'b0}}, frac};
  assign sfc_prod   = {{SW{1'b0}}, s3_s_q} * {{SW{1'b0}}, one_m_frac};

  always_ff @(posedge clk_i) begin
    s4_sf_q   <= SW'(sf_prod >> FRAC_BITS);
    s4_sfc_q  <= SW'(sfc_prod >> FRAC_BITS);
    s4_v_q    <= s3_v_q;
    s4_base_q <= s3_base_q;
    s4_sect_q <= s3_sect_q;
  end

  // Fade and rise levels, then the sector picks the channel order.
  assign fade_prod = {{SW{1'b0}}, s4_v_q} * {{SW{1'b0}}, ONE - s4_sf_q};
  assign rise_prod = {{SW{1'b0}}, s4_v_q} * {{SW{1'b0}}, ONE - s4_sfc_q};
  assign fade      = SW'(fade_prod >> FRAC_BITS);
  assign rise      = SW'(rise_prod >> FRAC_BITS);

  always_comb begin
    case (s4_sect_q)
      SECT_RY: begin
        red_c = s4_v_q;    green_c = rise;      blue_c = s4_base_q;
      end
      SECT_YG: begin
        red_c = fade;      green_c = s4_v_q;    blue_c = s4_base_q;
      end
      SECT_GC: begin
        red_c = s4_base_q; green_c = s4_v_q;    blue_c = rise;
      end
      SECT_CB: begin
        red_c = s4_base_q; green_c = fade;      blue_c = s4_v_q;
      end
      SECT_BM: begin
        red_c = rise;      green_c = s4_base_q; blue_c = s4_v_q;
      end
      default: begin
        red_c = s4_v_q;    green_c = s4_base_q; blue_c = fade;
      end
    endcase
  end

  // Output registers, each channel cut to its field.
  always_ff @(posedge clk_i) begin
    red_q   <= CH_W'(red_c);
    green_q <= CH_W'(green_c);
    blue_q  <= CH_W'(blue_c);
  end

  assign valid_o     = valid_q[STAGES-1];
  assign red_q12_o   = red_q;
  assign green_q12_o = green_q;
  assign blue_q12_o  = blue_q;

endmodule

// File: rtl/core/hsv2rgb_frac_div.sv
`timescale 1ns / 1ps

module hsv2rgb_frac_div #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic [hsv2rgb_pkg::REM_W-1:0]  rem_i,
  output logic [FRAC_BITS-1:0]           frac_o
);
  import hsv2rgb_pkg::*;

  // The dividend is the sector remainder scaled up by the fraction bits.
  localparam int unsigned XW = REM_W + FRAC_BITS;
  localparam int unsigned K  = XW;
  localparam int unsigned MW = FRAC_BITS + 1;
  localparam longint unsigned RECIP_L = (64'd1 << K) / 64'(HUE_SECTOR);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam logic [XW-1:0] DIVISOR = XW'(HUE_SECTOR);

  logic [XW-1:0]    x;
  logic [XW+MW-1:0] est_prod;
  logic [XW-1:0]    x_q;
  logic [FRAC_BITS-1:0] q0_q;
  logic [XW-1:0]    back_prod;
  logic [XW-1:0]    resid;
  logic [FRAC_BITS-1:0] frac_q;

  assign x = {rem_i, {FRAC_BITS{1'b0}}};

  // First step: the reciprocal estimate is low by at most one.
  assign est_prod = {{MW{1'b0}}, x} * {{XW{1'b0}}, RECIP};

  always_ff @(posedge clk_i) begin
    x_q  <= x;
    q0_q <= FRAC_BITS'(est_prod >> K);
  end

  // Second step: the residue tells whether the estimate needs one more.
  assign back_prod = {{(XW-FRAC_BITS){1'b0}}, q0_q} * DIVISOR;
  assign resid     = x_q - back_prod;

  always_ff @(posedge clk_i) begin
    if (resid >= DIVISOR) begin
      frac_q <= q0_q + FRAC_BITS'(1);
    end else begin
      frac_q <= q0_q;
    end
  end

  assign frac_o = frac_q;

endmodule

// File: bench/hsv_to_rgb_checker.sv
`timescale 1ns / 1ps

module hsv_to_rgb_checker #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_centideg_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  sat_q12_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  val_q12_i,
  input  logic                          valid_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  red_q12_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  green_q12_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  blue_q12_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  import hsv2rgb_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_pixel_t;

  // Pixels still owed by the converter, oldest first.
  rgb_pixel_t rgb_owed_q[$];

  // Computes the RGB pixel for one HSV item with truncating fixed-point products.
  function automatic rgb_pixel_t hsv_pixel_to_rgb(logic [HUE_W-1:0] hue_in,
                                                  logic [CH_W-1:0]  sat_in,
                                                  logic [CH_W-1:0]  val_in);
    longint unsigned one;
    longint unsigned hue;
    longint unsigned sat;
    longint unsigned val;
    longint unsigned frac;
    longint unsigned base;
    longint unsigned fade;
    longint unsigned rise;
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    sector_e         sect;
    rgb_pixel_t      pix;

    one = 64'd1 << FRAC_BITS;
    hue = 64'((hue_in > HUE_MAX) ? HUE_MAX : hue_in);
    sat = (sat_in > one) ? one : 64'(sat_in);
    val = (val_in > one) ? one : 64'(val_in);

    if (sat == 0) begin
      // Without saturation the pixel is grey at the value level.
      r = val;
      g = val;
      b = val;
    end else begin
      sect = sector_e'(hue / HUE_SECTOR);
      frac = ((hue % HUE_SECTOR) << FRAC_BITS) / HUE_SECTOR;
      base = (val * (one - sat)) >> FRAC_BITS;
      fade = (val * (one - ((sat * frac) >> FRAC_BITS))) >> FRAC_BITS;
      rise = (val * (one - ((sat * (one - frac)) >> FRAC_BITS))) >> FRAC_BITS;
      case (sect)
        SECT_RY: begin r = val;  g = rise; b = base; end
        SECT_YG: begin r = fade; g = val;  b = base; end
        SECT_GC: begin r = base; g = val;  b = rise; end
        SECT_CB: begin r = base; g = fade; b = val;  end
        SECT_BM: begin r = rise; g = base; b = val;  end
        default: begin r = val;  g = base; b = fade; end
      endcase
    end

    // Channels wider than the field are cut to the field width.
    pix.red   = r[CH_W-1:0];
    pix.green = g[CH_W-1:0];
    pix.blue  = b[CH_W-1:0];
    return pix;
  endfunction

  // Prints one line for a failed check and counts it.
  task automatic report_mismatch(string what, logic [CH_W-1:0] got, logic [CH_W-1:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // Compare each result with the oldest owed pixel, then record any newly taken item.
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_pixel_t want;
    if (!rst_ni) begin
      rgb_owed_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (valid_i) begin
        if (rgb_owed_q.size() == 0) begin
          report_mismatch("result with no item outstanding", red_q12_i, '0);
        end else begin
          want = rgb_owed_q.pop_front();
          if (red_q12_i !== want.red)     report_mismatch("red_q12", red_q12_i, want.red);
          if (green_q12_i !== want.green) report_mismatch("green_q12", green_q12_i, want.green);
          if (blue_q12_i !== want.blue)   report_mismatch("blue_q12", blue_q12_i, want.blue);
        end
      end
      if (start_i && !busy_i) begin
        rgb_owed_q.push_back(hsv_pixel_to_rgb(hue_centideg_i, sat_q12_i, val_q12_i));
      end
      pending_o <= rgb_owed_q.size();
    end
  end

endmodule

// File: bench/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;

  import hsv2rgb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 400;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [HUE_W-1:0]  hue;
  logic [CH_W-1:0]   sat;
  logic [CH_W-1:0]   val;
  logic              valid;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;
  int unsigned       fail_count;
  int unsigned       pending;

  hsv_to_rgb_converter u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .hue_centideg_i (hue),
    .sat_q12_i      (sat),
    .val_q12_i      (val),
    .valid_o        (valid),
    .red_q12_o      (red),
    .green_q12_o    (green),
    .blue_q12_o     (blue)
  );

  hsv_to_rgb_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .hue_centideg_i (hue),
    .sat_q12_i      (sat),
    .val_q12_i      (val),
    .valid_i        (valid),
    .red_q12_i      (red),
    .green_q12_i    (green),
    .blue_q12_i     (blue),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one pixel, waits until it is taken, then sometimes leaves a gap.
  task automatic push_pixel(logic [HUE_W-1:0] h, logic [CH_W-1:0] s, logic [CH_W-1:0] v,
                            bit steady);
    start <= 1'b1;
    hue   <= h;
    sat   <= s;
    val   <= v;
    do @(posedge clk); while (busy);
    if (!steady && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Waits, with a bound, until the converter owes no more pixels.
  task automatic wait_for_results();
    int unsigned cycles;
    cycles = 0;
    do begin
      @(posedge clk);
      cycles++;
    end while (pending != 0 && cycles < 200);
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned      i;
    int unsigned      pick;
    logic [HUE_W-1:0] h;
    logic [CH_W-1:0]  s;
    logic [CH_W-1:0]  v;

    rst_n = 1'b0;
    start = 1'b0;
    hue   = '0;
    sat   = '0;
    val   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sector edges, full and partial saturation.
    push_pixel(16'd0,     13'd4096, 13'd4096, 1'b0);
    push_pixel(16'd1,     13'd4096, 13'd4096, 1'b0);
    push_pixel(16'd5999,  13'd4096, 13'd4096, 1'b0);
    push_pixel(16'd6000,  13'd2048, 13'd4096, 1'b0);
    push_pixel(16'd11999, 13'd4096, 13'd3000, 1'b0);
    push_pixel(16'd12000, 13'd1000, 13'd4096, 1'b0);
    push_pixel(16'd18000, 13'd4096, 13'd4096, 1'b0);
    push_pixel(16'd23999, 13'd3000, 13'd2000, 1'b0);
    push_pixel(16'd24000, 13'd4096, 13'd4096, 1'b0);
    push_pixel(16'd30000, 13'd4096, 13'd4096, 1'b0);
    push_pixel(16'd35999, 13'd4096, 13'd4096, 1'b0);
    // Hue past the last sector is clamped.
    push_pixel(16'd36000, 13'd4096, 13'd4096, 1'b0);
    push_pixel(16'd50000, 13'd100,  13'd8000, 1'b0);
    push_pixel(16'd65535, 13'd8191, 13'd8191, 1'b0);
    // Zero saturation gives grey.
    push_pixel(16'd0,     13'd0,    13'd4096, 1'b0);
    push_pixel(16'd20000, 13'd0,    13'd8191, 1'b0);
    push_pixel(16'd7000,  13'd0,    13'd0,    1'b0);
    // Saturation or value above one is clamped to one.
    push_pixel(16'd3000,  13'd8191, 13'd4096, 1'b0);
    push_pixel(16'd9000,  13'd4096, 13'd8191, 1'b0);
    push_pixel(16'd33000, 13'd4097, 13'd4097, 1'b0);
    // Smallest nonzero levels and a black pixel.
    push_pixel(16'd15000, 13'd1,    13'd1,    1'b0);
    push_pixel(16'd0,     13'd1,    13'd4096, 1'b0);
    push_pixel(16'd27000, 13'd4096, 13'd0,    1'b0);
    push_pixel(16'd32767, 13'd2222, 13'd3333, 1'b0);

    // Let the pipeline run dry before the random part.
    start <= 1'b0;
    wait_for_results();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) h = HUE_W'($urandom_range(65535));
      else if (pick == 1) h = HUE_W'($urandom_range(5) * 6000 + ($urandom_range(1) ? 5999 : 0));
      else h = HUE_W'($urandom_range(35999));

      pick = $urandom_range(19);
      if (pick == 0) s = '0;
      else if (pick < 5) s = CH_W'($urandom_range(8191));
      else if (pick == 5) s = 13'd4096;
      else s = CH_W'($urandom_range(4096, 1));

      pick = $urandom_range(19);
      if (pick < 4) v = CH_W'($urandom_range(8191));
      else if (pick == 4) v = 13'd4096;
      else if (pick == 5) v = '0;
      else v = CH_W'($urandom_range(4096));

      // A middle stretch runs back to back with no gaps.
      push_pixel(h, s, v, (i >= 150 && i < 250));

      if (i == 300) begin
        start <= 1'b0;
        wait_for_results();
      end
    end

    start <= 1'b0;
    wait_for_results();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: hsv_to_rgb_converter.f
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_frac_div.sv
rtl/core/hsv_to_rgb_converter.sv
bench/hsv_to_rgb_checker.sv
bench/hsv_to_rgb_converter_tb.sv
